// ===== rtl/ipeaf_pkg.sv =====
// Shared types, codes and special-use range constants for the egress address filter.
package ipeaf_pkg;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

    localparam int V4_SPECIAL_COUNT = 14;

    localparam logic [31:0] V4_SPECIAL_NET [V4_SPECIAL_COUNT] = '{
        32'h00000000, 32'h0a000000, 32'h64400000, 32'h7f000000, 32'ha9fe0000,
        32'hac100000, 32'hc0000000, 32'hc0000200, 32'hc0a80000, 32'hc6120000,
        32'hc6336400, 32'hcb007100, 32'he0000000, 32'hf0000000
    };

    localparam logic [5:0] V4_SPECIAL_LEN [V4_SPECIAL_COUNT] = '{
        6'd8, 6'd8, 6'd10, 6'd8, 6'd16, 6'd12, 6'd24,
        6'd24, 6'd16, 6'd15, 6'd24, 6'd24, 6'd4, 6'd4
    };

    localparam logic [31:0] V6_MAPPED_TAG   = 32'h0000ffff;
    localparam logic [7:0]  V6_MCAST_TOP    = 8'hff;
    localparam logic [9:0]  V6_LINK_LOCAL   = 10'h3fa;  // fe80::/10
    localparam logic [9:0]  V6_SITE_LOCAL   = 10'h3fb;  // fec0::/10
    localparam logic [6:0]  V6_UNIQUE_LOCAL = 7'h7e;    // fc00::/7
    localparam logic [31:0] V6_DOC_PREFIX   = 32'h20010db8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // transaction accepted this cycle
        logic rd_en;     // read one slot of the table
        logic finish;    // last compare in flight, load the result
    } t_dp_cmd;

    typedef struct packed {
        logic        is_ipv6;
        logic [63:0] net_high;
        logic [63:0] net_low;
        logic [7:0]  prefix;
    } t_slot_entry;

    function automatic logic special_v4(input logic [31:0] a);
        logic        hit;
        logic [31:0] m;
        hit = 1'b0;
        for (int i = 0; i < V4_SPECIAL_COUNT; i++) begin
            m = ~(32'hffffffff >> V4_SPECIAL_LEN[i]);
            if ((a & m) == (V4_SPECIAL_NET[i] & m)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic special_v6(input logic [63:0] h, input logic [63:0] l);
        logic sp;
        sp = 1'b0;
        if (h == 64'd0 && (l == 64'd0 || l == 64'd1)) begin
            sp = 1'b1;
        end else if (h[63:56] == V6_MCAST_TOP) begin
            sp = 1'b1;
        end else if (h[63:54] == V6_LINK_LOCAL || h[63:54] == V6_SITE_LOCAL) begin
            sp = 1'b1;
        end else if (h == 64'd0 && l[63:32] == V6_MAPPED_TAG) begin
            sp = special_v4(l[31:0]);
        end else if (h[63:57] == V6_UNIQUE_LOCAL) begin
            sp = 1'b1;
        end else if (h[63:32] == V6_DOC_PREFIX) begin
            sp = 1'b1;
        end
        return sp;
    endfunction

endpackage

// ===== rtl/ipeaf_ctrl.sv =====
// Sequencer for the filter: accepts transactions and sweeps the allow table.
module ipeaf_ctrl #(
    parameter int ALLOW_SLOTS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    input  logic                                    i_command,
    output logic                                    busy,
    output ipeaf_pkg::t_dp_cmd                      o_cmd,
    output logic [((ALLOW_SLOTS > 1) ? $clog2(ALLOW_SLOTS) : 1)-1:0] o_rd_addr,
    output logic                                    o_result_valid
);
    import ipeaf_pkg::*;

    localparam int SLOT_W = (ALLOW_SLOTS > 1) ? $clog2(ALLOW_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ALLOW_SLOTS - 1);

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_slot_cnt, n_slot_cnt;
    logic              r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_slot_cnt <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot_cnt <= n_slot_cnt;
            r_done     <= n_done;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_slot_cnt = r_slot_cnt;
        n_done     = 1'b0;
        o_cmd      = '0;
        busy       = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    if (i_command == CMD_WRITE) begin
                        // write lands at the accept edge, result follows at once
                        n_done = 1'b1;
                    end else begin
                        n_state    = ST_SCAN;
                        n_slot_cnt = '0;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_slot_cnt == LAST_SLOT) begin
                    n_state = ST_FINISH;
                end else begin
                    n_slot_cnt = r_slot_cnt + 1'b1;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_done       = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr      = r_slot_cnt;
    assign o_result_valid = r_done;

    a_check_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_CHECK) |=> (r_state == ST_SCAN && r_slot_cnt == '0))
        else $error("accepted check did not start the table sweep");

    a_write_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_WRITE) |=> (r_done && r_state == ST_IDLE))
        else $error("write transaction did not produce its result");

    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |=> (r_done && !busy))
        else $error("sweep finished without a result strobe");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_slot_cnt <= LAST_SLOT))
        else $error("slot counter ran past the table");

endmodule

// ===== rtl/ipeaf_dpath.sv =====
// Datapath: allow table, prefix compare, special-use classifier and result registers.
module ipeaf_dpath #(
    parameter int ALLOW_SLOTS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ipeaf_pkg::t_dp_cmd                      i_cmd,
    input  logic [((ALLOW_SLOTS > 1) ? $clog2(ALLOW_SLOTS) : 1)-1:0] i_rd_addr,
    input  logic                                    i_cfg_we,
    input  logic                                    i_cfg_wdata,
    input  logic                                    i_command,
    input  logic                                    i_is_ipv6,
    input  logic [63:0]                             i_addr_high,
    input  logic [63:0]                             i_addr_low,
    input  logic [3:0]                              i_entry_slot,
    input  logic                                    i_entry_enable,
    input  logic [7:0]                              i_prefix_bits,
    output logic                                    o_allowed,
    output logic                                    o_list_hit,
    output logic                                    o_special_use
);
    import ipeaf_pkg::*;

    localparam int SLOT_W = (ALLOW_SLOTS > 1) ? $clog2(ALLOW_SLOTS) : 1;

    t_slot_entry            mem [ALLOW_SLOTS];
    t_slot_entry            r_rd_data;
    logic [ALLOW_SLOTS-1:0] r_slot_valid;
    logic                   r_cmp_en;
    logic                   r_deny_private;

    logic [63:0] r_addr_high, r_addr_low;
    logic        r_is_ipv6;
    logic        r_special;
    logic        r_hit;
    logic        r_allowed, r_list_hit, r_special_use;

    logic [63:0]       addr_high_s, addr_low_s;
    logic [7:0]        prefix_sat;
    logic [8:0]        wr_slot;
    logic              wr_in_range;
    logic              do_write;
    logic [SLOT_W-1:0] wr_idx;
    t_slot_entry       wr_entry;

    logic [127:0] mask128;
    logic [31:0]  mask32;
    logic         v6_match, v4_match, slot_match, hit_final;

    // IPv4 ignores everything above bit 31, both stored and checked
    assign addr_high_s = i_is_ipv6 ? i_addr_high : 64'd0;
    assign addr_low_s  = i_is_ipv6 ? i_addr_low : {32'd0, i_addr_low[31:0]};

    always_comb begin
        if (i_is_ipv6) begin
            prefix_sat = (i_prefix_bits > V6_MAX_PREFIX) ? V6_MAX_PREFIX : i_prefix_bits;
        end else begin
            prefix_sat = (i_prefix_bits > V4_MAX_PREFIX) ? V4_MAX_PREFIX : i_prefix_bits;
        end
    end

    assign wr_slot     = {5'd0, i_entry_slot};
    assign wr_in_range = wr_slot < 9'(ALLOW_SLOTS);
    assign wr_idx      = wr_slot[SLOT_W-1:0];
    assign do_write    = i_cmd.capture && (i_command == CMD_WRITE) && wr_in_range;

    assign wr_entry.is_ipv6  = i_is_ipv6;
    assign wr_entry.net_high = addr_high_s;
    assign wr_entry.net_low  = addr_low_s;
    assign wr_entry.prefix   = prefix_sat;

    // slot table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[wr_idx] <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid   <= '0;
            r_cmp_en       <= 1'b0;
            r_deny_private <= 1'b1;
        end else begin
            if (do_write) begin
                r_slot_valid[wr_idx] <= i_entry_enable;
            end
            r_cmp_en <= i_cmd.rd_en && r_slot_valid[i_rd_addr];
            if (i_cfg_we) begin
                r_deny_private <= i_cfg_wdata;
            end
        end
    end

    // compare of the slot read in the previous cycle
    assign mask128  = ~({128{1'b1}} >> r_rd_data.prefix);
    assign mask32   = ~(32'hffffffff >> r_rd_data.prefix);
    assign v6_match = ((({r_addr_high, r_addr_low}) ^
                        ({r_rd_data.net_high, r_rd_data.net_low})) & mask128) == 128'd0;
    assign v4_match = ((r_addr_low[31:0] ^ r_rd_data.net_low[31:0]) & mask32) == 32'd0;
    assign slot_match = r_cmp_en && (r_rd_data.is_ipv6 == r_is_ipv6) &&
                        (r_is_ipv6 ? v6_match : v4_match);
    assign hit_final  = r_hit || slot_match;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr_high <= addr_high_s;
            r_addr_low  <= addr_low_s;
            r_is_ipv6   <= i_is_ipv6;
            r_hit       <= 1'b0;
        end else begin
            r_hit <= hit_final;
        end
        // address is stable for the whole sweep
        r_special <= r_is_ipv6 ? special_v6(r_addr_high, r_addr_low)
                               : special_v4(r_addr_low[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && i_command == CMD_WRITE) begin
            r_allowed     <= 1'b0;
            r_list_hit    <= 1'b0;
            r_special_use <= 1'b0;
        end else if (i_cmd.finish) begin
            r_allowed     <= hit_final || !r_deny_private || !r_special;
            r_list_hit    <= hit_final;
            r_special_use <= r_special;
        end
    end

    assign o_allowed     = r_allowed;
    assign o_list_hit    = r_list_hit;
    assign o_special_use = r_special_use;

endmodule

// ===== rtl/ip_egress_address_filter.sv =====
// Top level of the egress address filter: CIDR allow table with special-use guard.
// Raise start for one cycle while busy is low to hand over a transaction; every
// transaction returns one result on o_allowed, o_list_hit and o_special_use, marked by
// o_result_valid for a single cycle, and the result cannot be held off. A write
// updates its slot at the accept edge and its all-zero result appears in the next
// cycle; busy stays low, so another transaction may follow immediately. A check
// sweeps the slot table one entry per cycle through its single read port, then does
// one final compare while busy stays high; the result shows in the cycle busy drops,
// and a new check may be accepted in that same cycle. The slot table comes out of
// reset empty, with no clearing pass. deny_private resets to 1 and should be written
// only while the block is idle.
module ip_egress_address_filter #(
    parameter int ALLOW_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic        i_is_ipv6,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [3:0]  i_entry_slot,
    input  logic        i_entry_enable,
    input  logic [7:0]  i_prefix_bits,
    output logic        o_result_valid,
    output logic        o_allowed,
    output logic        o_list_hit,
    output logic        o_special_use
);
    import ipeaf_pkg::*;

    localparam int SLOT_W = (ALLOW_SLOTS > 1) ? $clog2(ALLOW_SLOTS) : 1;

    t_dp_cmd           dp_cmd;
    logic [SLOT_W-1:0] rd_addr;

    ipeaf_ctrl #(
        .ALLOW_SLOTS (ALLOW_SLOTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_command      (i_command),
        .busy           (busy),
        .o_cmd          (dp_cmd),
        .o_rd_addr      (rd_addr),
        .o_result_valid (o_result_valid)
    );

    ipeaf_dpath #(
        .ALLOW_SLOTS (ALLOW_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_rd_addr      (rd_addr),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_command      (i_command),
        .i_is_ipv6      (i_is_ipv6),
        .i_addr_high    (i_addr_high),
        .i_addr_low     (i_addr_low),
        .i_entry_slot   (i_entry_slot),
        .i_entry_enable (i_entry_enable),
        .i_prefix_bits  (i_prefix_bits),
        .o_allowed      (o_allowed),
        .o_list_hit     (o_list_hit),
        .o_special_use  (o_special_use)
    );

endmodule
